// ===== sv/chck_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions of the Chaskey counter-mode cipher.
package chck_pkg;

  localparam int unsigned CHCK_BLOCK_BYTES  = 16;
  localparam int unsigned CHCK_ROUNDS       = 16;
  localparam int unsigned CHCK_QUEUE_DEPTH  = 2;
  localparam int unsigned CHCK_RESULT_DEPTH = 2;

  localparam int unsigned CHCK_ROT_A = 27;
  localparam int unsigned CHCK_ROT_B = 24;
  localparam int unsigned CHCK_ROT_C = 16;
  localparam int unsigned CHCK_ROT_D = 19;
  localparam int unsigned CHCK_ROT_E = 25;

  typedef enum logic [1:0] {
    REG_KEY_LOW    = 2'd0,
    REG_KEY_HIGH   = 2'd1,
    REG_NONCE_LOW  = 2'd2,
    REG_NONCE_HIGH = 2'd3
  } chck_reg_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_WRITE
  } chck_state_e;

  // One classified work item: counter value, data and per-byte XOR enables.
  typedef struct packed {
    logic [127:0]                  ctr;
    logic [127:0]                  data;
    logic [CHCK_BLOCK_BYTES-1:0]   mask;
  } chck_entry_t;

  function automatic logic [31:0] chck_rotr(input logic [31:0] v, input int unsigned s);
    chck_rotr = (v >> s) | (v << (32 - s));
  endfunction

  // One Chaskey round; state is {w3, w2, w1, w0}.
  function automatic logic [127:0] chck_round(input logic [127:0] st);
    logic [31:0] w0, w1, w2, w3;
    w0 = st[31:0];
    w1 = st[63:32];
    w2 = st[95:64];
    w3 = st[127:96];
    w0 = w0 + w1;
    w1 = chck_rotr(w1, CHCK_ROT_A) ^ w0;
    w2 = w2 + w3;
    w3 = chck_rotr(w3, CHCK_ROT_B) ^ w2;
    w2 = w2 + w1;
    w0 = chck_rotr(w0, CHCK_ROT_C) + w3;
    w3 = chck_rotr(w3, CHCK_ROT_D) ^ w0;
    w1 = chck_rotr(w1, CHCK_ROT_E) ^ w2;
    w2 = chck_rotr(w2, CHCK_ROT_C);
    chck_round = {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] chck_bswap(input logic [127:0] v);
    for (int j = 0; j < CHCK_BLOCK_BYTES; j++) begin
      chck_bswap[8*j +: 8] = v[8*(CHCK_BLOCK_BYTES-1-j) +: 8];
    end
  endfunction

  // Byte 15 is least significant, carry runs toward byte 0.
  function automatic logic [127:0] chck_ctr_inc(input logic [127:0] c);
    logic [127:0] num;
    num = chck_bswap(c);
    num = num + 128'd1;
    chck_ctr_inc = chck_bswap(num);
  endfunction

  // Enable byte j when j is below the clamped count.
  function automatic logic [CHCK_BLOCK_BYTES-1:0] chck_byte_mask(input logic [4:0] n);
    logic [4:0] n_eff;
    n_eff = (n > 5'(CHCK_BLOCK_BYTES)) ? 5'(CHCK_BLOCK_BYTES) : n;
    for (int j = 0; j < CHCK_BLOCK_BYTES; j++) begin
      chck_byte_mask[j] = (5'(j) < n_eff);
    end
  endfunction

  function automatic logic [127:0] chck_mask_expand(input logic [CHCK_BLOCK_BYTES-1:0] m);
    for (int j = 0; j < CHCK_BLOCK_BYTES; j++) begin
      chck_mask_expand[8*j +: 8] = {8{m[j]}};
    end
  endfunction

endpackage

// ===== sv/chck_fifo.sv =====
`timescale 1ns / 1ps
// Small synchronous queue with push/full and pop/empty sides.
module chck_fifo import chck_pkg::*; #(
  parameter int unsigned DEPTH = CHCK_QUEUE_DEPTH,
  parameter int unsigned WIDTH = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/chck_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts blocks, tracks the running counter, classifies byte counts.
module chck_front import chck_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [63:0]  block_low_i,
  input  logic [63:0]  block_high_i,
  input  logic [4:0]   valid_bytes_i,
  input  logic         restart_i,
  input  logic [127:0] nonce_i,
  output logic         entry_push_o,
  input  logic         entry_full_i,
  output chck_entry_t  entry_o
);

  logic [127:0] ctr_q, ctr_d, ctr_use;
  logic         accept;

  assign full_o       = entry_full_i;
  assign accept       = push_i && !entry_full_i;
  assign entry_push_o = accept;

  // Reload from the nonce first, then advance only for a non-empty block.
  assign ctr_use = restart_i ? nonce_i : ctr_q;

  always_comb begin
    entry_o.ctr  = ctr_use;
    entry_o.data = {block_high_i, block_low_i};
    entry_o.mask = chck_byte_mask(valid_bytes_i);
    ctr_d        = ctr_q;
    if (accept) begin
      ctr_d = (entry_o.mask != '0) ? chck_ctr_inc(ctr_use) : ctr_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

endmodule

// ===== sv/chck_core.sv =====
`timescale 1ns / 1ps
// Back end: Even-Mansour Chaskey keystream on one shared round unit, then the XOR.
module chck_core import chck_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [127:0] key_i,
  input  logic         entry_valid_i,
  input  chck_entry_t  entry_i,
  output logic         entry_pop_o,
  output logic         res_push_o,
  input  logic         res_full_i,
  output logic [127:0] res_o
);

  localparam int unsigned RW = $clog2(CHCK_ROUNDS);

  chck_state_e                 state_q, state_d;
  logic [RW-1:0]               rnd_q;
  logic [127:0]                w_q;
  logic [127:0]                data_q;
  logic [CHCK_BLOCK_BYTES-1:0] mask_q;
  logic                        load;

  assign entry_pop_o = load;
  assign res_o = data_q ^ ((w_q ^ key_i) & chck_mask_expand(mask_q));

  always_comb begin
    state_d    = state_q;
    load       = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      CORE_IDLE: begin
        load = entry_valid_i;
      end
      CORE_ROUND: begin
        if (rnd_q == RW'(CHCK_ROUNDS - 1)) state_d = CORE_WRITE;
      end
      CORE_WRITE: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          load    = entry_valid_i;
          state_d = CORE_IDLE;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
    // Empty blocks skip the rounds and pass straight through.
    if (load) begin
      state_d = (entry_i.mask == '0) ? CORE_WRITE : CORE_ROUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        rnd_q <= '0;
      end else if (state_q == CORE_ROUND) begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      w_q    <= entry_i.ctr ^ key_i;
      data_q <= entry_i.data;
      mask_q <= entry_i.mask;
    end else if (state_q == CORE_ROUND) begin
      w_q <= chck_round(w_q);
    end
  end

endmodule

// ===== sv/chaskey_ctr_cipher_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Chaskey counter-mode cipher unit.
//
// Usage: write key and nonce through the cfg port (cfg_we_i, cfg_idx_i,
// cfg_data_i) while the unit is idle. Push one 16-byte block per
// transaction with push/full; restart_i reloads the running counter from
// the nonce before that block. Results leave through empty/pop, oldest
// first, one per block.
// Path: a block with a non-zero byte count goes through the item queue,
// the load, the 16 rounds and the write state into the result queue; a
// zero-count block skips the rounds. The single round unit works on one
// block at a time (16 rounds, one per cycle); the key XOR and write-out
// overlap the load of the next block. The front end keeps taking blocks
// until the item queue fills.
// Reset: all queues empty, key, nonce and running counter cleared.
// Stall: when pop is held low the result queue fills, then the round unit
// holds its finished result, then the item queue fills and full rises.
module chaskey_ctr_cipher_unit import chck_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = CHCK_QUEUE_DEPTH,
  parameter int unsigned RESULT_DEPTH = CHCK_RESULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        restart_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o
);

  logic [63:0] key_low_q, key_high_q, nonce_low_q, nonce_high_q;

  chck_entry_t  front_entry, mid_entry;
  logic         mid_push, mid_full, mid_pop, mid_empty;
  logic         res_push, res_full;
  logic [127:0] res_data, res_out;

  // Configuration registers; decode the index by name.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      nonce_low_q  <= '0;
      nonce_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (chck_reg_e'(cfg_idx_i))
        REG_KEY_LOW:    key_low_q    <= cfg_data_i;
        REG_KEY_HIGH:   key_high_q   <= cfg_data_i;
        REG_NONCE_LOW:  nonce_low_q  <= cfg_data_i;
        REG_NONCE_HIGH: nonce_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: counter tracking and byte-count classification.
  chck_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .valid_bytes_i (valid_bytes_i),
    .restart_i     (restart_i),
    .nonce_i       ({nonce_high_q, nonce_low_q}),
    .entry_push_o  (mid_push),
    .entry_full_i  (mid_full),
    .entry_o       (front_entry)
  );

  // Item queue decouples the front end from the round unit.
  chck_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(chck_entry_t))
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .full_o  (mid_full),
    .wdata_i (front_entry),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .rdata_o (mid_entry)
  );

  // Back end: keystream generation and XOR.
  chck_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         ({key_high_q, key_low_q}),
    .entry_valid_i (!mid_empty),
    .entry_i       (mid_entry),
    .entry_pop_o   (mid_pop),
    .res_push_o    (res_push),
    .res_full_i    (res_full),
    .res_o         (res_data)
  );

  // Result queue lets the round unit continue while the receiver stalls.
  chck_fifo #(
    .DEPTH (RESULT_DEPTH),
    .WIDTH (128)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_data),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_out)
  );

  assign result_low_o  = res_out[63:0];
  assign result_high_o = res_out[127:64];

  // The round unit never offers a result the queue cannot take.
  a_res_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // The round unit only draws from a non-empty item queue.
  a_mid_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("item queue popped while empty");

  // An accepted block is waiting in the item queue on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !mid_empty)
    else $error("accepted block missing from item queue");

endmodule
